>>> hw/rtl/lcd_cell_tint_ghost_renderer_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LCD cell tint and ghost renderer
// Shared concurrent-check forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LCD_CELL_TINT_GHOST_RENDERER_UNIT_DEFINES_SVH
`define LCD_CELL_TINT_GHOST_RENDERER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LCTGR_ASSERT_IMP(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LCTGR_ASSERT_NXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lctgr_pkg.sv
// ----------------------------------------------------------------------------
// lctgr_pkg
// Types, sizes and constants of the LCD cell tint and ghost renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package lctgr_pkg;

    // Panel and cell limits
    localparam int MAX_PANEL_WIDTH  = 256;
    localparam int MAX_PANEL_HEIGHT = 256;
    localparam int MAX_CELL         = 8;
    localparam int CELL_W           = $clog2(MAX_CELL + 1);
    localparam int SUB_W            = $clog2(MAX_CELL);

    // Ghost store
    localparam int GHOST_DEPTH = MAX_PANEL_WIDTH * MAX_PANEL_HEIGHT;
    localparam int GHOST_AW    = $clog2(GHOST_DEPTH);

    // Field widths
    localparam int XY_W       = 11;
    localparam int PANEL_W    = 9;
    localparam int DRAWN_W    = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int PANEL_RESET = 160;

    // Fixed point: coverage 8.8, weights and dim Q0.8
    localparam int COV_FULL   = 65280;
    localparam int KEEP_W     = 166;
    localparam int GHOST_W    = 90;
    localparam int EDGE_D     = 200;
    localparam int LEVEL_STEP = 85;
    localparam int ROUND_HALF = COV_FULL * 128;
    localparam int RECIP_255  = 32'h8081;   // floor(x/255) = (x*RECIP_255)>>23, x < 2^16

    // Palettes, {red, green, blue}
    localparam logic [23:0] PAL_LIT [4] = '{24'hFFFFFF, 24'h6EDC9A, 24'hF0C050, 24'hC8CCC0};
    localparam logic [23:0] PAL_INK [4] = '{24'h000000, 24'h103A28, 24'h382208, 24'h20221E};

    typedef enum logic [1:0] {
        MODE_PIXEL  = 2'd0,
        MODE_BLANK  = 2'd1,
        MODE_FORGET = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TINT_SELECT  = 3'd0,
        REG_STRUCTURE_ON = 3'd1,
        REG_FRAME_FORMAT = 3'd2,
        REG_PANEL_WIDTH  = 3'd3,
        REG_PANEL_HEIGHT = 3'd4,
        REG_DRAWN_WIDTH  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [7:0]  gray_value;
        logic        frame_end;
    } in_item_t;

    typedef struct packed {
        logic [XY_W-1:0] out_x;
        logic [XY_W-1:0] out_y;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        logic            last;
    } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/lctgr_ram.sv
// ----------------------------------------------------------------------------
// lctgr_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module lctgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old word when the same entry is written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lcd_cell_tint_ghost_renderer_unit.sv
// ----------------------------------------------------------------------------
// lcd_cell_tint_ghost_renderer_unit
// Turns guest LCD pixels into tinted, ghosted, cell-expanded host pixels.
// ----------------------------------------------------------------------------
// Each accepted item is one guest pixel; it yields cell*cell host pixels, one
// per cycle unless stalled, in row order (sub row outer, sub column inner),
// with last on the final one. With structure off the cell is 1 and an item
// yields one pixel, so items can stream at one per cycle when not stalled;
// with structure on an item holds the output stage for its cell*cell (4 to 64)
// host pixels, and that output port sets the sustained rate. Accept to first
// result passes ghost read, blend, tint product, dim and round, divide by 255.
// All state effects (cell-size tracking, history flag, ghost write) happen at
// accept, so items that give no result (forget, unused mode, off-panel) end at
// accept. The ghost store is a 64K x 8 RAM addressed by (pixel_y, pixel_x); it
// is read and written in the accept cycle, read-before-write, so consecutive
// items on the same entry see each other's updates without forwarding. It has
// no reset: blending against an entry never written since reset gives
// undefined colors. Configuration writes are always taken (cfg_ready is tied
// high) and must only happen while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcd_cell_tint_ghost_renderer_unit_defines.svh"

module lcd_cell_tint_ghost_renderer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  lctgr_pkg::in_item_t                 pix_item,
    output logic                                res_valid,
    input  logic                                res_stall,
    output lctgr_pkg::out_item_t                res_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lctgr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lctgr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Per-item sideband carried down the pipe
    typedef struct packed {
        logic                          blank;
        logic [lctgr_pkg::CELL_W-1:0]  side;
        logic [lctgr_pkg::XY_W-1:0]    bx;
        logic [lctgr_pkg::XY_W-1:0]    by;
    } tag_t;

    // ---------------- configuration registers ----------------
    logic [1:0]                        tint_reg;
    logic                              struct_reg;
    logic                              fmt_reg;
    logic [lctgr_pkg::PANEL_W-1:0]     pw_reg;
    logic [lctgr_pkg::PANEL_W-1:0]     ph_reg;
    logic [lctgr_pkg::DRAWN_W-1:0]     drawn_reg;

    // ---------------- control state ----------------
    logic [lctgr_pkg::CELL_W-1:0]      cur_cell_reg, cur_cell_next;
    logic                              hist_reg, hist_next;

    // ---------------- accept-side decode ----------------
    logic                              adv;
    logic                              acc;
    logic                              panel_ok;
    logic                              on_panel;
    logic [14:0]                       cell_sum;
    logic [lctgr_pkg::CELL_W-1:0]      cell_cfg;
    logic                              hist_eff;
    logic [7:0]                        cov;
    logic                              start;
    logic                              use_hist;
    logic                              ram_we;
    logic [lctgr_pkg::GHOST_AW-1:0]    ghost_addr;
    logic [7:0]                        ghost_rd;

    // ---------------- pipeline ----------------
    logic                              a_valid_reg, b_valid_reg, c_valid_reg;
    logic                              d_valid_reg, e_valid_reg;
    logic                              a_blank_reg;
    logic [lctgr_pkg::CELL_W-1:0]      a_cell_reg;
    logic [7:0]                        a_px_reg, a_py_reg, a_g_reg;
    logic                              a_hist_reg;
    tag_t                              b_tag_reg, c_tag_reg, d_tag_reg, e_tag_reg;
    tag_t                              b_tag_next;
    logic [15:0]                       b_v_reg, b_v_next;
    logic [23:0]                       c_s_reg [3];
    logic [23:0]                       c_s_next [3];
    logic [15:0]                       d_ub_reg [3];
    logic [15:0]                       d_ue_reg [3];
    logic [15:0]                       d_ub_next [3];
    logic [15:0]                       d_ue_next [3];
    logic [7:0]                        e_body_reg [3];
    logic [7:0]                        e_edge_reg [3];
    logic [7:0]                        e_body_next [3];
    logic [7:0]                        e_edge_next [3];

    // ---------------- output stage ----------------
    logic [lctgr_pkg::SUB_W-1:0]       sx_reg, sx_next;
    logic [lctgr_pkg::SUB_W-1:0]       sy_reg, sy_next;
    logic [lctgr_pkg::CELL_W-1:0]      cell_m1;
    logic                              sx_end, sy_end;
    logic                              e_last;
    logic                              on_edge;

    // ============================================================
    // Configuration port
    // ============================================================
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_reg   <= '0;
            struct_reg <= 1'b0;
            fmt_reg    <= 1'b0;
            pw_reg     <= lctgr_pkg::PANEL_W'(lctgr_pkg::PANEL_RESET);
            ph_reg     <= lctgr_pkg::PANEL_W'(lctgr_pkg::PANEL_RESET);
            drawn_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (lctgr_pkg::cfg_reg_t'(cfg_index))
                lctgr_pkg::REG_TINT_SELECT:  tint_reg   <= cfg_data[1:0];
                lctgr_pkg::REG_STRUCTURE_ON: struct_reg <= cfg_data[0];
                lctgr_pkg::REG_FRAME_FORMAT: fmt_reg    <= cfg_data[0];
                lctgr_pkg::REG_PANEL_WIDTH:  pw_reg     <= cfg_data[lctgr_pkg::PANEL_W-1:0];
                lctgr_pkg::REG_PANEL_HEIGHT: ph_reg     <= cfg_data[lctgr_pkg::PANEL_W-1:0];
                lctgr_pkg::REG_DRAWN_WIDTH:  drawn_reg  <= cfg_data[lctgr_pkg::DRAWN_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // ============================================================
    // Cell size: round(drawn/panel) clamped to 2..MAX_CELL, or 1 with structure off.
    // round(d/p) >= k  <=>  d + p/2 >= k*p, so a row of compares
    // against constant multiples replaces the division.
    // ============================================================
    always_comb
    begin
        cell_sum = 15'(drawn_reg) + 15'(pw_reg >> 1);
        cell_cfg = lctgr_pkg::CELL_W'(2);
        for (int k = 3; k <= lctgr_pkg::MAX_CELL; k++)
        begin
            if (cell_sum >= 15'(k) * 15'(pw_reg))
            begin
                cell_cfg = lctgr_pkg::CELL_W'(k);
            end
        end
        if (!struct_reg)
        begin
            cell_cfg = lctgr_pkg::CELL_W'(1);
        end
    end

    // ============================================================
    // Accept and state update
    // ============================================================
    // The pipe moves as a whole whenever the output stage can take a new item.
    assign adv       = !e_valid_reg || (!res_stall && e_last);
    assign pix_stall = !adv;
    assign acc       = pix_valid && adv;

    assign panel_ok = (pw_reg != '0) && (ph_reg != '0);
    assign on_panel = (11'(pix_item.pixel_x) < 11'(pw_reg))
                   && (11'(pix_item.pixel_x) < 11'(lctgr_pkg::MAX_PANEL_WIDTH))
                   && (11'(pix_item.pixel_y) < 11'(ph_reg))
                   && (11'(pix_item.pixel_y) < 11'(lctgr_pkg::MAX_PANEL_HEIGHT));

    // A cell-size change drops the history before this pixel uses it.
    assign hist_eff = hist_reg && (cell_cfg == cur_cell_reg);

    // Two-bit dark level maps to 255 - 85*level
    assign cov = fmt_reg
               ? 8'(8'd255 - 8'(8'(pix_item.gray_value[1:0]) * 8'(lctgr_pkg::LEVEL_STEP)))
               : pix_item.gray_value;

    assign ghost_addr = lctgr_pkg::GHOST_AW'(pix_item.pixel_y)
                          * lctgr_pkg::GHOST_AW'(lctgr_pkg::MAX_PANEL_WIDTH)
                      + lctgr_pkg::GHOST_AW'(pix_item.pixel_x);

    always_comb
    begin
        cur_cell_next = cur_cell_reg;
        hist_next     = hist_reg;
        start         = 1'b0;
        use_hist      = 1'b0;
        ram_we        = 1'b0;
        if (acc)
        begin
            unique case (pix_item.mode)
                lctgr_pkg::MODE_PIXEL,
                lctgr_pkg::MODE_BLANK:
                begin
                    if (panel_ok)
                    begin
                        cur_cell_next = cell_cfg;
                        start         = on_panel;
                        if (pix_item.mode == lctgr_pkg::MODE_BLANK || !struct_reg)
                        begin
                            hist_next = 1'b0;
                        end
                        else
                        begin
                            // structure mode: blend, remember, frame_end arms history
                            use_hist  = hist_eff;
                            ram_we    = on_panel;
                            hist_next = pix_item.frame_end || hist_eff;
                        end
                    end
                end
                lctgr_pkg::MODE_FORGET: hist_next = 1'b0;
                lctgr_pkg::MODE_NONE:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_cell_reg <= '0;
            hist_reg     <= 1'b0;
        end
        else
        begin
            cur_cell_reg <= cur_cell_next;
            hist_reg     <= hist_next;
        end
    end

    // Ghost store: read old coverage and write the new one in the accept cycle
    lctgr_ram #(
        .WIDTH (8),
        .DEPTH (lctgr_pkg::GHOST_DEPTH)
    ) u_ghost (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ghost_addr),
        .wr_data (cov),
        .rd_en   (acc),
        .rd_addr (ghost_addr),
        .rd_data (ghost_rd)
    );

    // ============================================================
    // Datapath
    // ============================================================
    always_comb
    begin
        // stage a -> b: blend coverage (8.8), place the cell origin
        b_v_next = a_hist_reg
                 ? 16'(16'(a_g_reg) * 16'(lctgr_pkg::KEEP_W))
                   + 16'(16'(ghost_rd) * 16'(lctgr_pkg::GHOST_W))
                 : {a_g_reg, 8'h00};
        b_tag_next.blank = a_blank_reg;
        b_tag_next.side  = a_cell_reg;
        b_tag_next.bx    = lctgr_pkg::XY_W'(lctgr_pkg::XY_W'(a_px_reg)
                                             * lctgr_pkg::XY_W'(a_cell_reg));
        b_tag_next.by    = lctgr_pkg::XY_W'(lctgr_pkg::XY_W'(a_py_reg)
                                             * lctgr_pkg::XY_W'(a_cell_reg));

        for (int c = 0; c < 3; c++)
        begin
            // b -> c: lit*v + ink*(full - v)
            c_s_next[c] = 24'(24'(lctgr_pkg::PAL_LIT[tint_reg][8*(2-c) +: 8]) * 24'(b_v_reg))
                        + 24'(24'(lctgr_pkg::PAL_INK[tint_reg][8*(2-c) +: 8])
                              * 24'(16'(16'(lctgr_pkg::COV_FULL) - b_v_reg)));
            // c -> d: dim (body 1.0, edge 0.78), add half, drop the 2^16 factor
            d_ub_next[c] = 16'(({c_s_reg[c], 8'h00} + 32'(lctgr_pkg::ROUND_HALF)) >> 16);
            d_ue_next[c] = 16'((32'(c_s_reg[c]) * 32'(lctgr_pkg::EDGE_D)
                                + 32'(lctgr_pkg::ROUND_HALF)) >> 16);
            // d -> e: divide by 255
            e_body_next[c] = 8'((32'(d_ub_reg[c]) * 32'(lctgr_pkg::RECIP_255)) >> 23);
            e_edge_next[c] = 8'((32'(d_ue_reg[c]) * 32'(lctgr_pkg::RECIP_255)) >> 23);
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= start;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // Stage payload, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_blank_reg <= (pix_item.mode == lctgr_pkg::MODE_BLANK);
            a_cell_reg  <= cell_cfg;
            a_px_reg    <= pix_item.pixel_x;
            a_py_reg    <= pix_item.pixel_y;
            a_g_reg     <= cov;
            a_hist_reg  <= use_hist;
            b_tag_reg   <= b_tag_next;
            b_v_reg     <= b_v_next;
            c_tag_reg   <= b_tag_reg;
            d_tag_reg   <= c_tag_reg;
            e_tag_reg   <= d_tag_reg;
            for (int c = 0; c < 3; c++)
            begin
                c_s_reg[c]    <= c_s_next[c];
                d_ub_reg[c]   <= d_ub_next[c];
                d_ue_reg[c]   <= d_ue_next[c];
                e_body_reg[c] <= e_body_next[c];
                e_edge_reg[c] <= e_edge_next[c];
            end
        end
    end

    // ============================================================
    // Output stage: walk the cell; when not stalled, one host pixel per cycle
    // ============================================================
    assign cell_m1 = lctgr_pkg::CELL_W'(e_tag_reg.side - lctgr_pkg::CELL_W'(1));
    assign sx_end  = (lctgr_pkg::CELL_W'(sx_reg) == cell_m1);
    assign sy_end  = (lctgr_pkg::CELL_W'(sy_reg) == cell_m1);
    assign e_last  = sx_end && sy_end;
    assign on_edge = struct_reg && (sx_end || sy_end);

    always_comb
    begin
        sx_next = sx_reg;
        sy_next = sy_reg;
        priority if (adv)
        begin
            sx_next = '0;
            sy_next = '0;
        end
        else if (!res_stall)
        begin
            if (sx_end)
            begin
                sx_next = '0;
                sy_next = lctgr_pkg::SUB_W'(sy_reg + lctgr_pkg::SUB_W'(1));
            end
            else
            begin
                sx_next = lctgr_pkg::SUB_W'(sx_reg + lctgr_pkg::SUB_W'(1));
            end
        end
        else
        begin
            // output stalled: hold the position
            sx_next = sx_reg;
            sy_next = sy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
        end
        else
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    assign res_valid = e_valid_reg;

    always_comb
    begin
        res_item.out_x = lctgr_pkg::XY_W'(e_tag_reg.bx + lctgr_pkg::XY_W'(sx_reg));
        res_item.out_y = lctgr_pkg::XY_W'(e_tag_reg.by + lctgr_pkg::XY_W'(sy_reg));
        res_item.last  = e_last;
        if (e_tag_reg.blank)
        begin
            res_item.red   = '0;
            res_item.green = '0;
            res_item.blue  = '0;
        end
        else if (on_edge)
        begin
            res_item.red   = e_edge_reg[0];
            res_item.green = e_edge_reg[1];
            res_item.blue  = e_edge_reg[2];
        end
        else
        begin
            res_item.red   = e_body_reg[0];
            res_item.green = e_body_reg[1];
            res_item.blue  = e_body_reg[2];
        end
    end

    // ============================================================
    // Checks
    // ============================================================
    `LCTGR_ASSERT_IMP(a_sub_in_cell, clk, rst_n, e_valid_reg,
        (lctgr_pkg::CELL_W'(sx_reg) < e_tag_reg.side)
            && (lctgr_pkg::CELL_W'(sy_reg) < e_tag_reg.side),
        "sub position outside the cell")
    `LCTGR_ASSERT_IMP(a_hold_mid_cell, clk, rst_n, e_valid_reg && !e_last, pix_stall,
        "item accepted while a cell is still being emitted")
    `LCTGR_ASSERT_NXT(a_frame_end_arms, clk, rst_n,
        pix_valid && !pix_stall && ram_we && pix_item.frame_end, hist_reg,
        "frame end in structure mode did not arm history")

endmodule

`default_nettype wire

>>> bench/lcd_cell_tint_ghost_renderer_checker.sv
// ----------------------------------------------------------------------------
// Renderer scoreboard
// Follows the register, guest pixel and host pixel channels of the renderer.
// It predicts the host pixels of every accepted guest pixel and compares each
// host pixel, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module lcd_cell_tint_ghost_renderer_checker
    import lctgr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pix_valid,
    input  logic                    pix_stall,
    input  in_item_t                pix_item,
    input  logic                    res_valid,
    input  logic                    res_stall,
    input  out_item_t               res_item,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      mismatch_count,
    output int                      pending_count,
    output int                      checked_count
);

    localparam int unsigned FULL_COV  = 65280;
    localparam int unsigned KEEP_WT   = 166;    // 0.65 in Q0.8
    localparam int unsigned GHOST_WT  = 90;     // 0.35 in Q0.8
    localparam int unsigned BODY_DIM  = 256;
    localparam int unsigned EDGE_DIM  = 200;    // 0.78 in Q0.8
    localparam int unsigned LEVEL_STEP_SIZE = 85;

    logic [1:0]     tint_sel;
    logic           structure;
    logic           two_bit;
    logic [8:0]     panel_w;
    logic [8:0]     panel_h;
    logic [13:0]    drawn_w;
    logic [7:0]     ghost [GHOST_DEPTH];
    bit             history;
    int unsigned    cell_now;
    out_item_t      host_q [$];
    int             fails = 0;
    int             checked = 0;

    // {lit r, lit g, lit b, ink r, ink g, ink b}
    function automatic logic [47:0] palette(logic [1:0] sel);
        case (sel)
            2'd1:    return 48'h6EDC9A_103A28;
            2'd2:    return 48'hF0C050_382208;
            2'd3:    return 48'hC8CCC0_20221E;
            default: return 48'hFFFFFF_000000;
        endcase
    endfunction

    function automatic logic [7:0] tint_channel(int unsigned lit, int unsigned ink,
                                                int unsigned cov, int unsigned dim);
        longint unsigned num;
        longint unsigned den;
        num = (64'(lit) * 64'(cov) + 64'(ink) * 64'(FULL_COV - cov)) * 64'(dim);
        den = 64'(FULL_COV) * 64'd256;
        return 8'((num + den / 2) / den);
    endfunction

    function automatic int unsigned cell_side();
        int unsigned want;
        if (!structure)
            return 1;
        want = (drawn_w + panel_w / 2) / panel_w;
        if (want < 2)
            want = 2;
        if (want > MAX_CELL)
            want = MAX_CELL;
        return want;
    endfunction

    task automatic push_host(int unsigned x, int unsigned y, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, bit fin);
        out_item_t px;
        px.out_x = XY_W'(x);
        px.out_y = XY_W'(y);
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.last  = fin;
        host_q.push_back(px);
    endtask

    task automatic predict_host_pixels(in_item_t it);
        int unsigned side;
        int unsigned lim_w;
        int unsigned lim_h;
        int unsigned g;
        int unsigned cov;
        int unsigned addr;
        bit          on_panel;
        bit          on_edge;
        logic [47:0] pal;
        logic [7:0]  body [3];
        logic [7:0]  dimmed [3];
        if (it.mode == MODE_NONE)
            return;
        if (it.mode == MODE_FORGET)
        begin
            history = 1'b0;
            return;
        end
        if (panel_w == 0 || panel_h == 0)
            return;
        side = cell_side();
        if (side != cell_now)
        begin
            cell_now = side;
            history  = 1'b0;
        end
        lim_w = (panel_w < MAX_PANEL_WIDTH) ? panel_w : MAX_PANEL_WIDTH;
        lim_h = (panel_h < MAX_PANEL_HEIGHT) ? panel_h : MAX_PANEL_HEIGHT;
        on_panel = (it.pixel_x < lim_w) && (it.pixel_y < lim_h);

        if (it.mode == MODE_BLANK)
        begin
            history = 1'b0;
            if (on_panel)
                for (int sy = 0; sy < side; sy++)
                    for (int sx = 0; sx < side; sx++)
                        push_host(it.pixel_x * side + sx, it.pixel_y * side + sy,
                                  8'h00, 8'h00, 8'h00, sx == side - 1 && sy == side - 1);
            return;
        end

        g   = two_bit ? 255 - it.gray_value[1:0] * LEVEL_STEP_SIZE : it.gray_value;
        pal = palette(tint_sel);

        if (!structure)
        begin
            history = 1'b0;
            if (!on_panel)
                return;
            if (tint_sel == 2'd0)
                push_host(it.pixel_x, it.pixel_y, 8'(g), 8'(g), 8'(g), 1'b1);
            else
                push_host(it.pixel_x, it.pixel_y,
                          tint_channel(pal[47:40], pal[23:16], g * 256, BODY_DIM),
                          tint_channel(pal[39:32], pal[15:8], g * 256, BODY_DIM),
                          tint_channel(pal[31:24], pal[7:0], g * 256, BODY_DIM), 1'b1);
            return;
        end

        if (on_panel)
        begin
            addr = it.pixel_y * MAX_PANEL_WIDTH + it.pixel_x;
            cov  = history ? g * KEEP_WT + ghost[addr] * GHOST_WT : g * 256;
            for (int c = 0; c < 3; c++)
            begin
                body[c]   = tint_channel(pal[47 - 8 * c -: 8], pal[23 - 8 * c -: 8], cov,
                                         BODY_DIM);
                dimmed[c] = tint_channel(pal[47 - 8 * c -: 8], pal[23 - 8 * c -: 8], cov,
                                         EDGE_DIM);
            end
            // last row and last column of the cell are dimmed
            for (int sy = 0; sy < side; sy++)
                for (int sx = 0; sx < side; sx++)
                begin
                    on_edge = (sx == side - 1) || (sy == side - 1);
                    push_host(it.pixel_x * side + sx, it.pixel_y * side + sy,
                              on_edge ? dimmed[0] : body[0],
                              on_edge ? dimmed[1] : body[1],
                              on_edge ? dimmed[2] : body[2],
                              sx == side - 1 && sy == side - 1);
                end
            ghost[addr] = 8'(g);
        end
        if (it.frame_end)
            history = 1'b1;
    endtask

    task automatic compare_host_pixel(out_item_t got);
        out_item_t want;
        checked++;
        if (host_q.size() == 0)
        begin
            fails++;
            if (fails <= 10)
                $display("unexpected host pixel x=%0d y=%0d rgb=%02h%02h%02h last=%0b",
                         got.out_x, got.out_y, got.red, got.green, got.blue, got.last);
            return;
        end
        want = host_q.pop_front();
        if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
            got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.last !== want.last)
        begin
            fails++;
            if (fails <= 10)
                $display("host pixel mismatch: expected x=%0d y=%0d rgb=%02h%02h%02h last=%0b, got x=%0d y=%0d rgb=%02h%02h%02h last=%0b",
                         want.out_x, want.out_y, want.red, want.green, want.blue, want.last,
                         got.out_x, got.out_y, got.red, got.green, got.blue, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_sel  = 2'd0;
            structure = 1'b0;
            two_bit   = 1'b0;
            panel_w   = 9'(PANEL_RESET);
            panel_h   = 9'(PANEL_RESET);
            drawn_w   = 14'd0;
            history   = 1'b0;
            cell_now  = 0;
            host_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_reg_t'(cfg_index))
                    REG_TINT_SELECT:  tint_sel  = cfg_data[1:0];
                    REG_STRUCTURE_ON: structure = cfg_data[0];
                    REG_FRAME_FORMAT: two_bit   = cfg_data[0];
                    REG_PANEL_WIDTH:  panel_w   = cfg_data[8:0];
                    REG_PANEL_HEIGHT: panel_h   = cfg_data[8:0];
                    REG_DRAWN_WIDTH:  drawn_w   = cfg_data[13:0];
                    default: ;
                endcase
            if (pix_valid && !pix_stall)
                predict_host_pixels(pix_item);
            if (res_valid && !res_stall)
                compare_host_pixel(res_item);
        end
        mismatch_count <= fails;
        pending_count  <= host_q.size();
        checked_count  <= checked;
    end

endmodule

>>> bench/tb_lcd_cell_tint_ghost_renderer_unit.sv
// ----------------------------------------------------------------------------
// Renderer testbench
// Drives guest pixels and register settings into the LCD cell renderer,
// with random idling and stalls on both channels; a scoreboard beside the
// block predicts and checks every host pixel.
// ----------------------------------------------------------------------------
module tb_lcd_cell_tint_ghost_renderer_unit;
    import lctgr_pkg::*;

    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int SETTLE_CYCLES  = 10;     // margin after the last predicted host pixel
    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no item moving anywhere

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   pix_valid = 1'b0;
    logic                   pix_stall;
    in_item_t               pix_item = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    out_item_t              res_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatches;
    int pending;
    int checked;

    // idle percentages for the current stretch of the run
    int send_idle_pct = 21;
    int recv_idle_pct = 45;
    int hold_requests = 0;
    int idle_cycles = 0;

    // Stimulus bookkeeping. The ghost store has no reset, so a blend must never
    // read an entry that was not written. We track written entries and whether
    // the history flag might be set; a forget item goes in first when needed.
    bit          ghost_written [GHOST_DEPTH];
    bit          maybe_history = 1'b0;
    bit          set_struct = 1'b0;
    int unsigned set_pw = PANEL_RESET;
    int unsigned set_ph = PANEL_RESET;

    int n_pixel = 0;
    int n_blank = 0;
    int n_forget = 0;
    int n_ignored = 0;
    int n_settings = 0;

    lcd_cell_tint_ghost_renderer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_item  (pix_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lcd_cell_tint_ghost_renderer_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_valid      (pix_valid),
        .pix_stall      (pix_stall),
        .pix_item       (pix_item),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_item       (res_item),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .pending_count  (pending),
        .checked_count  (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus asks
    // for one. The sender keeps offering during the hold, so the block fills.
    initial
    begin : receiver
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests > holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog: ends the run if nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one item, idling first at random; returns at the accepting edge.
    // Valid is left high so back-to-back items never toggle it within a step.
    task automatic send_item(in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item  <= it;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
    endtask

    task automatic feed(mode_t m, int unsigned x, int unsigned y, int unsigned g, bit fe);
        in_item_t    it;
        in_item_t    flush;
        int unsigned addr;
        int unsigned lim_w;
        int unsigned lim_h;
        bit          on_panel;
        it.mode       = m;
        it.pixel_x    = 8'(x);
        it.pixel_y    = 8'(y);
        it.gray_value = 8'(g);
        it.frame_end  = fe;
        addr  = it.pixel_y * MAX_PANEL_WIDTH + it.pixel_x;
        lim_w = (set_pw < MAX_PANEL_WIDTH) ? set_pw : MAX_PANEL_WIDTH;
        lim_h = (set_ph < MAX_PANEL_HEIGHT) ? set_ph : MAX_PANEL_HEIGHT;
        on_panel = set_pw != 0 && set_ph != 0 && it.pixel_x < lim_w && it.pixel_y < lim_h;

        // would blend against a never-written ghost entry: drop history first
        if (m == MODE_PIXEL && set_struct && on_panel && !ghost_written[addr] && maybe_history)
        begin
            flush.mode       = MODE_FORGET;
            flush.pixel_x    = 8'($urandom);
            flush.pixel_y    = 8'($urandom);
            flush.gray_value = 8'($urandom);
            flush.frame_end  = 1'($urandom);
            send_item(flush);
            n_forget++;
            maybe_history = 1'b0;
        end
        send_item(it);

        case (m)
            MODE_PIXEL:  n_pixel++;
            MODE_BLANK:  n_blank++;
            MODE_FORGET: n_forget++;
            default:     n_ignored++;
        endcase
        if (m == MODE_FORGET)
            maybe_history = 1'b0;
        if (m == MODE_PIXEL && set_struct)
        begin
            if (on_panel)
                ghost_written[addr] = 1'b1;
            if (fe)
                maybe_history = 1'b1;
        end
    endtask

    // Wait until every predicted host pixel has come out and the pipe is empty.
    task automatic settle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, int unsigned v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= CFG_DATA_W'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Registers change only with the block idle; all six are written each time.
    task automatic configure(int unsigned tint, int unsigned strc, int unsigned fmt,
                             int unsigned pw, int unsigned ph, int unsigned dw);
        settle();
        write_reg(REG_TINT_SELECT, tint);
        write_reg(REG_STRUCTURE_ON, strc);
        write_reg(REG_FRAME_FORMAT, fmt);
        write_reg(REG_PANEL_WIDTH, pw);
        write_reg(REG_PANEL_HEIGHT, ph);
        write_reg(REG_DRAWN_WIDTH, dw);
        cfg_valid <= 1'b0;
        set_struct = strc[0];
        set_pw     = pw;
        set_ph     = ph;
        n_settings++;
    endtask

    // One random stretch under a fixed setting. With structure on, most items
    // walk the panel in raster order as whole frames (frame_end on the last
    // pixel) so the ghost blend gets exercised; the rest is noise.
    task automatic run_phase(int unsigned tint, int unsigned strc, int unsigned fmt,
                             int unsigned pw, int unsigned ph, int unsigned dw,
                             int unsigned count, bit hold);
        int unsigned done;
        int unsigned cx;
        int unsigned cy;
        int unsigned lim_w;
        int unsigned lim_h;
        int unsigned pick;
        int unsigned x;
        int unsigned y;
        mode_t       m;
        configure(tint, strc, fmt, pw, ph, dw);
        if (hold)
            hold_requests++;
        lim_w = (pw < MAX_PANEL_WIDTH) ? pw : MAX_PANEL_WIDTH;
        lim_h = (ph < MAX_PANEL_HEIGHT) ? ph : MAX_PANEL_HEIGHT;
        cx    = 0;
        cy    = 0;
        done  = 0;
        while (done < count)
        begin
            if (strc != 0 && $urandom_range(0, 99) < 85)
            begin
                feed(MODE_PIXEL, cx, cy, $urandom_range(0, 255),
                     cx == lim_w - 1 && cy == lim_h - 1);
                done++;
                cx++;
                if (cx == lim_w)
                begin
                    cx = 0;
                    cy = (cy + 1 == lim_h) ? 0 : cy + 1;
                end
            end
            else
            begin
                pick = $urandom_range(0, 9);
                // each coordinate lands anywhere a quarter of the time, mostly off the panel
                x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, lim_w - 1);
                y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, lim_h - 1);
                if (pick < 5)
                    m = MODE_PIXEL;
                else if (pick < 7)
                    m = MODE_BLANK;
                else if (pick < 9)
                    m = MODE_FORGET;
                else
                    m = MODE_NONE;
                feed(m, x, y, $urandom_range(0, 255), $urandom_range(0, 7) == 0);
                if (m != MODE_NONE)
                    done++;
            end
        end
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // reset settings: plain grey, no cell, 160x160 panel
        feed(MODE_PIXEL, 0, 0, 8'h00, 1'b0);
        feed(MODE_PIXEL, 159, 159, 8'hFF, 1'b1);
        feed(MODE_PIXEL, 160, 3, 8'h4D, 1'b0);          // just off the right edge
        feed(MODE_NONE, 7, 7, 8'hAA, 1'b1);             // unused mode, ignored
        feed(MODE_BLANK, 12, 34, 8'h55, 1'b0);          // single black pixel
        feed(MODE_FORGET, 1, 2, 8'h33, 1'b0);

        // tint-only, two-bit dark levels; upper bits of the byte must not matter
        configure(1, 0, 1, 160, 160, 0);
        for (int lvl = 0; lvl < 4; lvl++)
            feed(MODE_PIXEL, lvl, 0, {6'($urandom), 2'(lvl)}, 1'b0);

        // structure on, 2x2 panel, cell 8: a fresh frame then a blended one
        configure(2, 1, 0, 2, 2, 16);
        feed(MODE_PIXEL, 0, 0, 8'h00, 1'b0);
        feed(MODE_PIXEL, 1, 0, 8'hFF, 1'b0);
        feed(MODE_PIXEL, 0, 1, 8'h80, 1'b0);
        feed(MODE_PIXEL, 1, 1, 8'h01, 1'b1);
        feed(MODE_PIXEL, 0, 0, 8'hFF, 1'b0);
        feed(MODE_PIXEL, 1, 0, 8'h00, 1'b0);
        feed(MODE_PIXEL, 0, 1, 8'hC8, 1'b0);
        feed(MODE_PIXEL, 1, 1, 8'h03, 1'b1);
        feed(MODE_BLANK, 1, 1, 8'h00, 1'b0);            // full black cell, history off
        feed(MODE_PIXEL, 5, 0, 8'h77, 1'b1);            // off panel, frame_end still counts

        // zero panel width: pixels and blanks give nothing
        configure(3, 1, 1, 0, 2, 16);
        feed(MODE_PIXEL, 0, 0, 8'h12, 1'b1);
        feed(MODE_BLANK, 0, 0, 8'h00, 1'b0);

        // oversized panel and largest drawn width: far corner at x=y=2047
        configure(0, 1, 0, 300, 256, 16383);
        feed(MODE_PIXEL, 255, 255, 8'hFF, 1'b1);

        // cell rounds to zero and is clamped to the minimum of 2
        configure(1, 1, 0, 1, 1, 0);
        feed(MODE_PIXEL, 0, 0, 8'h00, 1'b1);
        feed(MODE_PIXEL, 0, 0, 8'h80, 1'b0);

        // ---- random part ----
        run_phase(1, 1, 0, 4, 3, 8, 60, 1'b0);          // cell 2
        run_phase(3, 1, 1, 3, 2, 24, 40, 1'b1);         // cell 8, long hold-off

        send_idle_pct = 45;
        recv_idle_pct = 21;
        run_phase(2, 0, 0, 256, 256, 8192, 80, 1'b1);   // streaming, hold-off
        run_phase(0, 1, 0, 5, 4, 22, 60, 1'b0);         // cell 4
        run_phase(0, 0, 1, 1, 1, 0, 40, 1'b0);          // one-pixel panel

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(2, 1, 1, 2, 2, 12, 50, 1'b0);         // cell 6
        run_phase(3, 1, 0, 6, 5, 18, 50, 1'b0);         // cell 3

        settle();
        $display("Run covered %0d pixels, %0d blanks, %0d forgets and %0d ignored items",
                 n_pixel, n_blank, n_forget, n_ignored);
        $display("under %0d register settings; %0d host pixels compared, %0d mismatches.",
                 n_settings, checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> lcd_cell_tint_ghost_renderer_unit.f
+incdir+hw/rtl
hw/rtl/lctgr_pkg.sv
hw/rtl/lctgr_ram.sv
hw/rtl/lcd_cell_tint_ghost_renderer_unit.sv
bench/lcd_cell_tint_ghost_renderer_checker.sv
bench/tb_lcd_cell_tint_ghost_renderer_unit.sv
